@@ design/first_fit_pool_allocator_core_defines.svh @@
// ----------------------------------------------------------------------------
// first fit pool allocator assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_POOL_ALLOCATOR_CORE_DEFINES_SVH

// condition holds at every edge
`define FFPA_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define FFPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFPA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ffpa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffpa_pkg
// constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int POOL_SIZE    = 4096;
    localparam int MAX_SEGMENTS = 64;
    localparam int SIZE_W       = $clog2(POOL_SIZE + 1);
    localparam int OFF_W        = $clog2(POOL_SIZE);
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ENTRY_W      = SIZE_W + 1;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2
    } op_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_FF_RD,
        ST_FF_EV,
        ST_FU_RD,
        ST_FU_EV,
        ST_NX_RD,
        ST_NX_EV,
        ST_PV_RD,
        ST_PV_EV,
        ST_MG_WR,
        ST_RS_DEC,
        ST_W_NX,
        ST_W_CUR,
        ST_UP_RD,
        ST_UP_WR,
        ST_DN_RD,
        ST_DN_WR,
        ST_OK,
        ST_FAIL
    } state_t;

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_MOVE,
        PH_OLD
    } phase_t;

    typedef enum logic [2:0] {
        RA_IDX,
        RA_NEXT,
        RA_PREV,
        RA_UP,
        RA_DN
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_INS,
        WR_CUR,
        WR_NX,
        WR_MERGE,
        WR_SHIFT
    } wr_sel_t;

    typedef enum logic [2:0] {
        K_HOLD,
        K_CNT,
        K_DEC,
        K_INC,
        K_MERGE,
        K_NEXT
    } k_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_SUB
    } cnt_op_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_OFF,
        RES_FF
    } res_sel_t;

    typedef struct packed {
        logic     latch;
        logic     scan_clr;
        logic     scan_next;
        rd_sel_t  rd_sel;
        logic     cap_seg;
        logic     cap_ff;
        logic     nx_load;
        logic     pv_load;
        logic     from_ram;
        wr_sel_t  wr_sel;
        k_op_t    k_op;
        cnt_op_t  cnt_op;
        logic     out_load;
        logic     out_ok;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic req_zero;
        logic scan_end;
        logic fit;
        logic fit_exact;
        logic full;
        logic fu_hit;
        logic fu_used;
        logic fu_past;
        logic has_next;
        logic has_prev;
        logic up_more;
        logic dn_more;
        logic dist_zero;
        logic shrink;
        logic same;
        logic grow_fit;
        logic grow_exact;
        logic nx_free;
        logic out_free;
    } dp_status_t;

endpackage

@@ design/first_fit_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core
// each request scans the segment table entry by entry and may shift entries to insert or remove one
// a move scans for the old segment, then for a first fit and again for the old one, with shifts up and down
// one request at a time, next taken once the result is in the output register
// reset: the init state sets entry 0 to the whole free pool, in_stall high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_pool_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [ffpa_pkg::OFF_W-1:0]  offset,
    input  logic [ffpa_pkg::SIZE_W-1:0] request_size,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        ok,
    output logic [ffpa_pkg::OFF_W-1:0]  result_offset
);

    ffpa_pkg::dp_cmd_t    cmd;
    ffpa_pkg::dp_status_t status;

    ffpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ffpa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (operation),
        .offset        (offset),
        .request_size  (request_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .result_offset (result_offset),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

@@ design/ffpa_ram.sv @@
// ----------------------------------------------------------------------------
// ffpa_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/ffpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffpa_ctrl
// request sequencer: scans, segment split, merge and table shifts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ffpa_pkg::dp_status_t status,
    output ffpa_pkg::dp_cmd_t    cmd
);

    ffpa_pkg::state_t state_reg, state_next;
    ffpa_pkg::phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffpa_pkg::ST_INIT;
            phase_reg <= ffpa_pkg::PH_MAIN;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ffpa_pkg::ST_INIT:
            begin
                cmd.wr_sel = ffpa_pkg::WR_INIT;
                state_next = ffpa_pkg::ST_IDLE;
            end
            ffpa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch    = 1'b1;
                    cmd.scan_clr = 1'b1;
                    phase_next   = ffpa_pkg::PH_MAIN;
                    state_next   = ffpa_pkg::ST_DISPATCH;
                end
            end
            ffpa_pkg::ST_DISPATCH:
            begin
                unique case (status.op)
                    ffpa_pkg::OP_ALLOC:
                        state_next = status.req_zero ? ffpa_pkg::ST_FAIL : ffpa_pkg::ST_FF_RD;
                    ffpa_pkg::OP_FREE:
                        state_next = ffpa_pkg::ST_FU_RD;
                    ffpa_pkg::OP_RESIZE:
                        state_next = status.req_zero ? ffpa_pkg::ST_FAIL : ffpa_pkg::ST_FU_RD;
                    default:
                        state_next = ffpa_pkg::ST_FAIL;
                endcase
            end
            ffpa_pkg::ST_FF_RD:
            begin
                cmd.rd_sel = ffpa_pkg::RA_IDX;
                state_next = status.scan_end ? ffpa_pkg::ST_FAIL : ffpa_pkg::ST_FF_EV;
            end
            ffpa_pkg::ST_FF_EV:
            begin
                if (status.fit)
                begin
                    cmd.cap_seg = 1'b1;
                    cmd.cap_ff  = 1'b1;
                    if (status.fit_exact)
                    begin
                        state_next = ffpa_pkg::ST_W_CUR;
                    end
                    else if (status.full)
                    begin
                        state_next = ffpa_pkg::ST_FAIL;
                    end
                    else
                    begin
                        cmd.k_op   = ffpa_pkg::K_CNT;
                        state_next = ffpa_pkg::ST_UP_RD;
                    end
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ffpa_pkg::ST_FF_RD;
                end
            end
            ffpa_pkg::ST_FU_RD:
            begin
                cmd.rd_sel = ffpa_pkg::RA_IDX;
                if (!status.scan_end)
                begin
                    state_next = ffpa_pkg::ST_FU_EV;
                end
                else
                begin
                    state_next = (phase_reg == ffpa_pkg::PH_OLD) ? ffpa_pkg::ST_OK
                                                                 : ffpa_pkg::ST_FAIL;
                end
            end
            ffpa_pkg::ST_FU_EV:
            begin
                if (status.fu_hit && status.fu_used)
                begin
                    cmd.cap_seg = 1'b1;
                    state_next  = ffpa_pkg::ST_NX_RD;
                end
                else if (status.fu_hit || status.fu_past)
                begin
                    state_next = (phase_reg == ffpa_pkg::PH_OLD) ? ffpa_pkg::ST_OK
                                                                 : ffpa_pkg::ST_FAIL;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ffpa_pkg::ST_FU_RD;
                end
            end
            ffpa_pkg::ST_NX_RD, ffpa_pkg::ST_NX_EV:
            begin
                cmd.rd_sel = ffpa_pkg::RA_NEXT;
                if (state_reg == ffpa_pkg::ST_NX_RD && status.has_next)
                begin
                    state_next = ffpa_pkg::ST_NX_EV;
                end
                else
                begin
                    cmd.nx_load  = 1'b1;
                    cmd.from_ram = (state_reg == ffpa_pkg::ST_NX_EV);
                    if (status.op == ffpa_pkg::OP_RESIZE && phase_reg == ffpa_pkg::PH_MAIN)
                    begin
                        state_next = ffpa_pkg::ST_RS_DEC;
                    end
                    else
                    begin
                        state_next = ffpa_pkg::ST_PV_RD;
                    end
                end
            end
            ffpa_pkg::ST_PV_RD, ffpa_pkg::ST_PV_EV:
            begin
                cmd.rd_sel = ffpa_pkg::RA_PREV;
                if (state_reg == ffpa_pkg::ST_PV_RD && status.has_prev)
                begin
                    state_next = ffpa_pkg::ST_PV_EV;
                end
                else
                begin
                    cmd.pv_load  = 1'b1;
                    cmd.from_ram = (state_reg == ffpa_pkg::ST_PV_EV);
                    state_next   = ffpa_pkg::ST_MG_WR;
                end
            end
            ffpa_pkg::ST_MG_WR:
            begin
                cmd.wr_sel = ffpa_pkg::WR_MERGE;
                cmd.k_op   = ffpa_pkg::K_MERGE;
                state_next = ffpa_pkg::ST_DN_RD;
            end
            ffpa_pkg::ST_RS_DEC:
            begin
                if (status.shrink)
                begin
                    if (status.nx_free)
                    begin
                        state_next = ffpa_pkg::ST_W_NX;
                    end
                    else if (status.full)
                    begin
                        state_next = ffpa_pkg::ST_FAIL;
                    end
                    else
                    begin
                        cmd.k_op   = ffpa_pkg::K_CNT;
                        state_next = ffpa_pkg::ST_UP_RD;
                    end
                end
                else if (status.same)
                begin
                    state_next = ffpa_pkg::ST_OK;
                end
                else if (status.grow_fit)
                begin
                    if (status.grow_exact)
                    begin
                        cmd.k_op   = ffpa_pkg::K_NEXT;
                        state_next = ffpa_pkg::ST_DN_RD;
                    end
                    else
                    begin
                        state_next = ffpa_pkg::ST_W_NX;
                    end
                end
                else
                begin
                    cmd.scan_clr = 1'b1;
                    phase_next   = ffpa_pkg::PH_MOVE;
                    state_next   = ffpa_pkg::ST_FF_RD;
                end
            end
            ffpa_pkg::ST_W_NX:
            begin
                cmd.wr_sel = ffpa_pkg::WR_NX;
                state_next = ffpa_pkg::ST_W_CUR;
            end
            ffpa_pkg::ST_W_CUR:
            begin
                cmd.wr_sel = ffpa_pkg::WR_CUR;
                if (phase_reg == ffpa_pkg::PH_MOVE)
                begin
                    cmd.scan_clr = 1'b1;
                    phase_next   = ffpa_pkg::PH_OLD;
                    state_next   = ffpa_pkg::ST_FU_RD;
                end
                else
                begin
                    state_next = ffpa_pkg::ST_OK;
                end
            end
            ffpa_pkg::ST_UP_RD:
            begin
                cmd.rd_sel = ffpa_pkg::RA_UP;
                if (status.up_more)
                begin
                    state_next = ffpa_pkg::ST_UP_WR;
                end
                else
                begin
                    cmd.wr_sel = ffpa_pkg::WR_INS;
                    cmd.cnt_op = ffpa_pkg::CNT_INC;
                    state_next = ffpa_pkg::ST_W_CUR;
                end
            end
            ffpa_pkg::ST_UP_WR:
            begin
                cmd.wr_sel = ffpa_pkg::WR_SHIFT;
                cmd.k_op   = ffpa_pkg::K_DEC;
                state_next = ffpa_pkg::ST_UP_RD;
            end
            ffpa_pkg::ST_DN_RD:
            begin
                cmd.rd_sel = ffpa_pkg::RA_DN;
                if (!status.dist_zero && status.dn_more)
                begin
                    state_next = ffpa_pkg::ST_DN_WR;
                end
                else
                begin
                    if (!status.dist_zero)
                    begin
                        cmd.cnt_op = ffpa_pkg::CNT_SUB;
                    end
                    if (status.op == ffpa_pkg::OP_RESIZE && phase_reg == ffpa_pkg::PH_MAIN)
                    begin
                        state_next = ffpa_pkg::ST_W_CUR;
                    end
                    else
                    begin
                        state_next = ffpa_pkg::ST_OK;
                    end
                end
            end
            ffpa_pkg::ST_DN_WR:
            begin
                cmd.wr_sel = ffpa_pkg::WR_SHIFT;
                cmd.k_op   = ffpa_pkg::K_INC;
                state_next = ffpa_pkg::ST_DN_RD;
            end
            ffpa_pkg::ST_OK:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_ok   = 1'b1;
                    if (phase_reg == ffpa_pkg::PH_OLD || status.op == ffpa_pkg::OP_ALLOC)
                    begin
                        cmd.res_sel = ffpa_pkg::RES_FF;
                    end
                    else if (status.op == ffpa_pkg::OP_FREE)
                    begin
                        cmd.res_sel = ffpa_pkg::RES_ZERO;
                    end
                    else
                    begin
                        cmd.res_sel = ffpa_pkg::RES_OFF;
                    end
                    state_next = ffpa_pkg::ST_IDLE;
                end
            end
            ffpa_pkg::ST_FAIL:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res_sel  = ffpa_pkg::RES_ZERO;
                    state_next   = ffpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffpa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/ffpa_dp.sv @@
// ----------------------------------------------------------------------------
// ffpa_dp
// segment table, scan accumulators, shift pointers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "first_fit_pool_allocator_core_defines.svh"

module ffpa_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [1:0]                         operation,
    input  logic [ffpa_pkg::OFF_W-1:0]         offset,
    input  logic [ffpa_pkg::SIZE_W-1:0]        request_size,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               ok,
    output logic [ffpa_pkg::OFF_W-1:0]         result_offset,
    input  ffpa_pkg::dp_cmd_t                  cmd,
    output ffpa_pkg::dp_status_t               status
);

    ffpa_pkg::op_t                     op_reg;
    logic [ffpa_pkg::OFF_W-1:0]        off_reg;
    logic [ffpa_pkg::SIZE_W-1:0]       req_reg;
    logic [ffpa_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic [ffpa_pkg::SIZE_W-1:0]       start_reg, start_next;
    logic [ffpa_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ffpa_pkg::CNT_W-1:0]        fi_reg;
    logic [ffpa_pkg::SIZE_W-1:0]       s_reg;
    logic [ffpa_pkg::SIZE_W-1:0]       ff_reg;
    logic [ffpa_pkg::SIZE_W-1:0]       n_reg;
    logic                              nfree_reg;
    logic [ffpa_pkg::SIZE_W-1:0]       p_reg;
    logic                              pfree_reg;
    logic [ffpa_pkg::CNT_W-1:0]        k_reg, k_next;
    logic [1:0]                        dist_reg, dist_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              ok_reg;
    logic [ffpa_pkg::OFF_W-1:0]        res_reg;

    logic                              ram_we;
    logic [ffpa_pkg::IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [ffpa_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata;
    logic                              r_used;
    logic [ffpa_pkg::SIZE_W-1:0]       r_size;

    logic [ffpa_pkg::CNT_W-1:0]        fi_p1, fi_m1, k_m1, k_pd;
    logic [ffpa_pkg::SIZE_W:0]         sum_sn;
    logic [ffpa_pkg::SIZE_W-1:0]       nx_size, ins_size, merge_size;
    logic                              out_free;

    assign r_used   = ram_rdata[ffpa_pkg::SIZE_W];
    assign r_size   = ram_rdata[ffpa_pkg::SIZE_W-1:0];
    assign fi_p1    = fi_reg + 1'b1;
    assign fi_m1    = fi_reg - 1'b1;
    assign k_m1     = k_reg - 1'b1;
    assign k_pd     = k_reg + ffpa_pkg::CNT_W'(dist_reg);
    assign sum_sn   = {1'b0, s_reg} + {1'b0, n_reg};
    assign nx_size  = ffpa_pkg::SIZE_W'(sum_sn - {1'b0, req_reg});
    assign ins_size = s_reg - req_reg;
    assign merge_size = (pfree_reg ? p_reg : '0) + s_reg + (nfree_reg ? n_reg : '0);
    assign out_free = !out_valid_reg || !out_stall;

    ffpa_ram #(
        .WIDTH (ffpa_pkg::ENTRY_W),
        .DEPTH (ffpa_pkg::MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (cmd.rd_sel)
            ffpa_pkg::RA_IDX:  ram_raddr = idx_reg[ffpa_pkg::IDX_W-1:0];
            ffpa_pkg::RA_NEXT: ram_raddr = fi_p1[ffpa_pkg::IDX_W-1:0];
            ffpa_pkg::RA_PREV: ram_raddr = fi_m1[ffpa_pkg::IDX_W-1:0];
            ffpa_pkg::RA_UP:   ram_raddr = k_m1[ffpa_pkg::IDX_W-1:0];
            ffpa_pkg::RA_DN:   ram_raddr = k_pd[ffpa_pkg::IDX_W-1:0];
            default:           ram_raddr = idx_reg[ffpa_pkg::IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b1;
        ram_waddr = fi_reg[ffpa_pkg::IDX_W-1:0];
        ram_wdata = '0;
        unique case (cmd.wr_sel)
            ffpa_pkg::WR_NONE:
            begin
                ram_we = 1'b0;
            end
            ffpa_pkg::WR_INIT:
            begin
                ram_waddr = '0;
                ram_wdata = {1'b0, ffpa_pkg::SIZE_W'(ffpa_pkg::POOL_SIZE)};
            end
            ffpa_pkg::WR_INS:
            begin
                ram_waddr = fi_p1[ffpa_pkg::IDX_W-1:0];
                ram_wdata = {1'b0, ins_size};
            end
            ffpa_pkg::WR_CUR:
            begin
                ram_wdata = {1'b1, req_reg};
            end
            ffpa_pkg::WR_NX:
            begin
                ram_waddr = fi_p1[ffpa_pkg::IDX_W-1:0];
                ram_wdata = {1'b0, nx_size};
            end
            ffpa_pkg::WR_MERGE:
            begin
                ram_waddr = pfree_reg ? fi_m1[ffpa_pkg::IDX_W-1:0]
                                      : fi_reg[ffpa_pkg::IDX_W-1:0];
                ram_wdata = {1'b0, merge_size};
            end
            ffpa_pkg::WR_SHIFT:
            begin
                ram_waddr = k_reg[ffpa_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        start_next = start_reg;
        if (cmd.scan_clr)
        begin
            idx_next   = '0;
            start_next = '0;
        end
        else if (cmd.scan_next)
        begin
            idx_next   = idx_reg + 1'b1;
            start_next = start_reg + r_size;
        end

        k_next    = k_reg;
        dist_next = dist_reg;
        unique case (cmd.k_op)
            ffpa_pkg::K_HOLD: k_next = k_reg;
            ffpa_pkg::K_CNT:  k_next = cnt_reg;
            ffpa_pkg::K_DEC:  k_next = k_m1;
            ffpa_pkg::K_INC:  k_next = k_reg + 1'b1;
            ffpa_pkg::K_MERGE:
            begin
                k_next    = pfree_reg ? fi_reg : fi_p1;
                dist_next = {1'b0, pfree_reg} + {1'b0, nfree_reg};
            end
            ffpa_pkg::K_NEXT:
            begin
                k_next    = fi_p1;
                dist_next = 2'd1;
            end
            default: k_next = k_reg;
        endcase

        case (cmd.cnt_op)
            ffpa_pkg::CNT_INC: cnt_next = cnt_reg + 1'b1;
            ffpa_pkg::CNT_SUB: cnt_next = cnt_reg - ffpa_pkg::CNT_W'(dist_reg);
            default:           cnt_next = cnt_reg;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= ffpa_pkg::CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        start_reg <= start_next;
        k_reg     <= k_next;
        dist_reg  <= dist_next;
        if (cmd.latch)
        begin
            op_reg  <= ffpa_pkg::op_t'(operation);
            off_reg <= offset;
            req_reg <= request_size;
        end
        if (cmd.cap_seg)
        begin
            fi_reg <= idx_reg;
            s_reg  <= r_size;
        end
        if (cmd.cap_ff)
        begin
            ff_reg <= start_reg;
        end
        if (cmd.nx_load)
        begin
            nfree_reg <= cmd.from_ram && !r_used;
            n_reg     <= r_size;
        end
        if (cmd.pv_load)
        begin
            pfree_reg <= cmd.from_ram && !r_used;
            p_reg     <= r_size;
        end
        if (cmd.out_load)
        begin
            ok_reg <= cmd.out_ok;
            case (cmd.res_sel)
                ffpa_pkg::RES_OFF: res_reg <= off_reg;
                ffpa_pkg::RES_FF:  res_reg <= ff_reg[ffpa_pkg::OFF_W-1:0];
                default:           res_reg <= '0;
            endcase
        end
    end

    always_comb
    begin
        status            = '0;
        status.op         = op_reg;
        status.req_zero   = (req_reg == '0);
        status.scan_end   = (idx_reg >= cnt_reg);
        status.fit        = !r_used && (r_size >= req_reg);
        status.fit_exact  = (r_size == req_reg);
        status.full       = (cnt_reg == ffpa_pkg::CNT_W'(ffpa_pkg::MAX_SEGMENTS));
        status.fu_hit     = (start_reg == {1'b0, off_reg});
        status.fu_used    = r_used;
        status.fu_past    = (start_reg > {1'b0, off_reg});
        status.has_next   = (fi_p1 < cnt_reg);
        status.has_prev   = (fi_reg != '0);
        status.up_more    = (k_reg > fi_p1);
        status.dn_more    = (k_pd < cnt_reg);
        status.dist_zero  = (dist_reg == 2'd0);
        status.shrink     = (req_reg < s_reg);
        status.same       = (req_reg == s_reg);
        status.grow_fit   = nfree_reg && (sum_sn >= {1'b0, req_reg});
        status.grow_exact = (sum_sn == {1'b0, req_reg});
        status.nx_free    = nfree_reg;
        status.out_free   = out_free;
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign result_offset = res_reg;

    `FFPA_ASSERT(a_cnt_range, (cnt_reg != '0) && (cnt_reg <= ffpa_pkg::CNT_W'(ffpa_pkg::MAX_SEGMENTS)), "segment count out of range")
    `FFPA_ASSERT_IMP(a_ins_room, cmd.cnt_op == ffpa_pkg::CNT_INC, cnt_reg < ffpa_pkg::CNT_W'(ffpa_pkg::MAX_SEGMENTS), "insert into full table")
    `FFPA_ASSERT_IMP(a_rm_room, cmd.cnt_op == ffpa_pkg::CNT_SUB, cnt_reg > ffpa_pkg::CNT_W'(dist_reg), "remove beyond table")
    `FFPA_ASSERT_NXT(a_out_load, cmd.out_load && out_free, out_valid_reg, "result register not loaded")

endmodule

@@ test/tb_first_fit_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_pool_allocator_core
// drives allocate, free and resize requests into the pool allocator, tracks the
// segment table in a local model and checks every result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_pool_allocator_core;

    localparam int TIMEOUT_CYCLES = 3000000;

    typedef struct {
        logic                          ok;
        logic [ffpa_pkg::OFF_W-1:0]    offset;
    } alloc_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    operation;
    logic [ffpa_pkg::OFF_W-1:0]    offset;
    logic [ffpa_pkg::SIZE_W-1:0]   request_size;
    logic                          out_valid;
    logic                          out_stall;
    logic                          ok;
    logic [ffpa_pkg::OFF_W-1:0]    result_offset;

    int unsigned    seg_size [ffpa_pkg::MAX_SEGMENTS];
    bit             seg_used [ffpa_pkg::MAX_SEGMENTS];
    int unsigned    seg_count;
    alloc_result_t  expected_results [$];
    int unsigned    live_offsets [$];
    int             mismatches;
    longint         cycles;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_off_cycles;

    first_fit_pool_allocator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .offset        (offset),
        .request_size  (request_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .result_offset (result_offset)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void table_insert(int unsigned i, int unsigned sz, bit used);
        if (seg_count >= ffpa_pkg::MAX_SEGMENTS || i > seg_count)
            return;
        for (int unsigned k = seg_count; k > i; k--)
        begin
            seg_size[k] = seg_size[k - 1];
            seg_used[k] = seg_used[k - 1];
        end
        seg_size[i] = sz;
        seg_used[i] = used;
        seg_count++;
    endfunction

    function automatic void table_remove(int unsigned i);
        if (i >= seg_count)
            return;
        for (int unsigned k = i; k + 1 < seg_count; k++)
        begin
            seg_size[k] = seg_size[k + 1];
            seg_used[k] = seg_used[k + 1];
        end
        seg_count--;
    endfunction

    function automatic int used_index(int unsigned off);
        int unsigned start;
        start = 0;
        for (int unsigned i = 0; i < seg_count; i++)
        begin
            if (start == off)
                return seg_used[i] ? int'(i) : -1;
            if (start > off)
                return -1;
            start += seg_size[i];
        end
        return -1;
    endfunction

    function automatic bit take_first_fit(int unsigned req, output int unsigned res);
        int unsigned start;
        start = 0;
        res = 0;
        if (req == 0)
            return 0;
        for (int unsigned i = 0; i < seg_count; i++)
        begin
            if (!seg_used[i] && seg_size[i] >= req)
            begin
                if (seg_size[i] > req)
                begin
                    if (seg_count >= ffpa_pkg::MAX_SEGMENTS)
                        return 0;
                    table_insert(i + 1, seg_size[i] - req, 0);
                    seg_size[i] = req;
                end
                seg_used[i] = 1;
                res = start;
                return 1;
            end
            start += seg_size[i];
        end
        return 0;
    endfunction

    function automatic void release_and_merge(int unsigned i);
        seg_used[i] = 0;
        if (i + 1 < seg_count && !seg_used[i + 1])
        begin
            seg_size[i] += seg_size[i + 1];
            table_remove(i + 1);
        end
        if (i > 0 && !seg_used[i - 1])
        begin
            seg_size[i - 1] += seg_size[i];
            table_remove(i);
        end
    endfunction

    function automatic bit resize_segment(int unsigned off, int unsigned req,
                                          output int unsigned res);
        int           f;
        int unsigned  i;
        int unsigned  s;
        int unsigned  n;
        int unsigned  r;
        bit           next_free;
        res = 0;
        n = 0;
        f = used_index(off);
        if (f < 0 || req == 0)
            return 0;
        i = f;
        s = seg_size[i];
        next_free = (i + 1 < seg_count) && !seg_used[i + 1];
        if (next_free)
            n = seg_size[i + 1];
        if (req < s)
        begin
            if (next_free)
                seg_size[i + 1] = n + (s - req);
            else
            begin
                if (seg_count >= ffpa_pkg::MAX_SEGMENTS)
                    return 0;
                table_insert(i + 1, s - req, 0);
            end
            seg_size[i] = req;
            res = off;
            return 1;
        end
        if (req == s)
        begin
            res = off;
            return 1;
        end
        if (next_free && s + n >= req)
        begin
            if (s + n == req)
                table_remove(i + 1);
            else
                seg_size[i + 1] = s + n - req;
            seg_size[i] = req;
            res = off;
            return 1;
        end
        if (!take_first_fit(req, r))
            return 0;
        f = used_index(off);
        if (f >= 0)
            release_and_merge(f);
        res = r;
        return 1;
    endfunction

    function automatic alloc_result_t predict_request(logic [1:0] op, int unsigned off,
                                                      int unsigned req);
        alloc_result_t  pr;
        int unsigned    res;
        int             f;
        bit             good;
        res = 0;
        good = 0;
        if (op == ffpa_pkg::OP_ALLOC)
            good = take_first_fit(req, res);
        else if (op == ffpa_pkg::OP_FREE)
        begin
            f = used_index(off);
            if (f >= 0)
            begin
                release_and_merge(f);
                good = 1;
            end
        end
        else if (op == ffpa_pkg::OP_RESIZE)
            good = resize_segment(off, req, res);
        if (!good)
            res = 0;
        pr.ok = good;
        pr.offset = res[ffpa_pkg::OFF_W-1:0];
        return pr;
    endfunction

    function automatic void pool_reset();
        for (int k = 0; k < ffpa_pkg::MAX_SEGMENTS; k++)
        begin
            seg_size[k] = 0;
            seg_used[k] = 0;
        end
        seg_size[0] = ffpa_pkg::POOL_SIZE;
        seg_count = 1;
    endfunction

    function automatic void refresh_live();
        int unsigned start;
        start = 0;
        live_offsets.delete();
        for (int unsigned i = 0; i < seg_count; i++)
        begin
            if (seg_used[i])
                live_offsets.push_back(start);
            start += seg_size[i];
        end
    endfunction

    task automatic send_request(logic [1:0] op, int unsigned off, int unsigned req);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        operation <= op;
        offset <= off[ffpa_pkg::OFF_W-1:0];
        request_size <= req[ffpa_pkg::SIZE_W-1:0];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_request(op, off, req));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic int unsigned pick_live();
        refresh_live();
        if (live_offsets.size() == 0)
            return $urandom_range(4095);
        return live_offsets[$urandom_range(live_offsets.size() - 1)];
    endfunction

    function automatic int unsigned pick_size();
        case ($urandom_range(9))
            0: return $urandom_range(4096, 1);
            1: return $urandom_range(8191);
            2: return $urandom_range(512, 1);
            default: return $urandom_range(96, 1);
        endcase
    endfunction

    task automatic random_request();
        int unsigned  sel;
        sel = $urandom_range(99);
        if (sel < 40)
            send_request(ffpa_pkg::OP_ALLOC, $urandom_range(4095), pick_size());
        else if (sel < 70)
            send_request(ffpa_pkg::OP_FREE, pick_live(), $urandom_range(8191));
        else if (sel < 92)
            send_request(ffpa_pkg::OP_RESIZE, pick_live(), pick_size());
        else
            send_request(2'($urandom_range(3)), $urandom_range(4095), $urandom_range(8191));
    endtask

    task automatic test_directed();
        send_request(ffpa_pkg::OP_ALLOC, 0, 0);
        send_request(2'd3, 0, 16);
        send_request(ffpa_pkg::OP_FREE, 0, 1);
        send_request(ffpa_pkg::OP_RESIZE, 0, 4);
        send_request(ffpa_pkg::OP_ALLOC, 4095, 8191);
        send_request(ffpa_pkg::OP_ALLOC, 0, 4096);
        send_request(ffpa_pkg::OP_ALLOC, 0, 1);
        send_request(ffpa_pkg::OP_FREE, 0, 0);
        send_request(ffpa_pkg::OP_ALLOC, 0, 100);
        send_request(ffpa_pkg::OP_ALLOC, 0, 200);
        send_request(ffpa_pkg::OP_ALLOC, 0, 300);
        send_request(ffpa_pkg::OP_FREE, 7, 0);
        send_request(ffpa_pkg::OP_RESIZE, 300, 0);
        send_request(ffpa_pkg::OP_RESIZE, 300, 50);
        send_request(ffpa_pkg::OP_RESIZE, 300, 50);
        send_request(ffpa_pkg::OP_RESIZE, 350, 500);
        send_request(ffpa_pkg::OP_RESIZE, 300, 600);
        send_request(ffpa_pkg::OP_RESIZE, 100, 90);
        send_request(ffpa_pkg::OP_RESIZE, 100, 1000);
        send_request(ffpa_pkg::OP_RESIZE, 0, 4000);
        send_request(ffpa_pkg::OP_FREE, 100, 0);
        send_request(ffpa_pkg::OP_FREE, 0, 0);
        send_request(ffpa_pkg::OP_FREE, 4095, 0);
        drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < ffpa_pkg::MAX_SEGMENTS + 2; i++)
            send_request(ffpa_pkg::OP_ALLOC, 0, 1);
        send_request(ffpa_pkg::OP_ALLOC, 0, 1);
        refresh_live();
        send_request(ffpa_pkg::OP_RESIZE, live_offsets[0], 1);
        send_request(ffpa_pkg::OP_FREE, live_offsets[1], 0);
        send_request(ffpa_pkg::OP_FREE, live_offsets[3], 0);
        send_request(ffpa_pkg::OP_ALLOC, 0, 1);
        for (int i = 0; i < 40; i++)
            send_request(ffpa_pkg::OP_FREE, pick_live(), 0);
        drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
            random_request();
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 3000;
        for (int i = 0; i < 20; i++)
            random_request();
        drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        alloc_result_t  want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result ok=%0b offset=%0d", ok, result_offset);
            end
            else
            begin
                want = expected_results.pop_front();
                if (ok !== want.ok || result_offset !== want.offset)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ok=%0b offset=%0d, got ok=%0b offset=%0d",
                                 want.ok, want.offset, ok, result_offset);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("tb_first_fit_pool_allocator_core NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = '0;
        offset = '0;
        request_size = '0;
        out_stall = 1'b0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        pool_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_back_pressure();
        test_random(260, 0, 0);
        test_random(260, 62, 0);
        test_random(260, 0, 62);
        test_random(260, 12, 12);
        if (expected_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("tb_first_fit_pool_allocator_core OK");
        else
            $display("tb_first_fit_pool_allocator_core NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/ffpa_pkg.sv
design/ffpa_ram.sv
design/ffpa_ctrl.sv
design/ffpa_dp.sv
design/first_fit_pool_allocator_core.sv
test/tb_first_fit_pool_allocator_core.sv
